// ===== rtl/mmpc_pkg.sv =====
// shared widths, command codes and types for the multiset mex prefix counter
// no dependencies
`default_nettype none

package mmpc_pkg;

    localparam int unsigned CMD_W    = 1;
    localparam int unsigned VALUE_W  = 11;
    localparam int unsigned COUNT_W  = 20;
    localparam int unsigned RESULT_W = 32;

    localparam logic [CMD_W-1:0] CMD_ADD    = 1'b0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [RESULT_W-1:0] t_result;

endpackage

`default_nettype wire

// ===== rtl/multiset_mex_prefix_count.sv =====
// Multiset of values 1..MAX_VALUE with saturating 20-bit counts. Each input beat adds
// (i_cmd = add) or removes one copy of i_value, and one output beat then gives the number
// of stored elements below the mex. Values of 0 or above MAX_VALUE change nothing.
// The multiset sits in two memories with registered reads: one holds each value's count
// next to a Fenwick tree of present values, the other a Fenwick tree of counts. An item
// passes an accept step, a lookup that also writes the first Fenwick node, one step per
// further node on the update path (at most clog2(MAX_VALUE+1)-1, none when the count does
// not change), a start step and a descent of clog2(MAX_VALUE+1) steps that finds the mex
// and sums the counts below it in the same walk. An out-of-range value skips the lookup.
// While the previous result is stalled at the output, a finished result waits in a done
// state with o_stall high, so no new item is taken before that result is sent.
// After reset a clearing pass writes zero to all MAX_VALUE+1 entries while o_stall is high.
// depends on mmpc_pkg
`default_nettype none

module multiset_mex_prefix_count
    import mmpc_pkg::*;
#(
    parameter int unsigned MAX_VALUE = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [CMD_W-1:0]    i_cmd,
    input  wire logic [VALUE_W-1:0]  i_value,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [RESULT_W-1:0]      o_count_below_mex
);

    localparam int unsigned AW    = $clog2(MAX_VALUE + 1);
    localparam int unsigned DEPTH = MAX_VALUE + 1;

    localparam logic [AW:0]   MAX_POS  = (AW + 1)'(MAX_VALUE);
    localparam logic [AW-1:0] MAX_ADDR = AW'(MAX_VALUE);
    localparam logic [AW-1:0] TOP_STEP = AW'(1) << (AW - 1);
    localparam logic [31:0]   MAX_V32  = 32'(MAX_VALUE);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_DSTART = 3'd4;
    localparam logic [2:0] S_DESC   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic [AW-1:0]      pres;
    } t_entry;

    t_entry  mem_a [DEPTH];
    t_result mem_b [DEPTH];

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [AW:0]      r_pos, n_pos;
    logic [AW-1:0]    r_step, n_step;
    logic             r_up, n_up;
    logic             r_pchg, n_pchg;
    t_result          r_acc, n_acc;
    logic             r_out_valid, n_out_valid;
    t_result          r_out_data, n_out_data;
    t_entry           r_rd_a;
    t_result          r_rd_b;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_a;
    t_result       wr_b;

    logic               w_in_range;
    logic [AW:0]        w_next_pos;
    t_result            w_delta_b;
    logic [AW-1:0]      w_delta_p;
    logic               w_slot_free;
    logic [AW:0]        w_cand;
    logic               w_take;
    logic [AW:0]        w_dpos_nx;
    t_result            w_acc_nx;
    logic [AW-1:0]      w_step_nx;
    logic [AW:0]        w_cand_nx;
    logic               w_is_add;
    logic               w_change;
    logic               w_lk_pchg;
    logic [COUNT_W-1:0] w_lk_cnt;
    t_result            w_lk_delta_b;
    logic [AW-1:0]      w_lk_delta_p;

    assign w_in_range  = (i_value != '0) && (32'(i_value) <= MAX_V32);
    assign w_next_pos  = r_pos + (r_pos & (~r_pos + (AW + 1)'(1)));
    assign w_delta_b   = r_up ? RESULT_W'(1) : '1;
    assign w_delta_p   = !r_pchg ? '0 : (r_up ? AW'(1) : '1);
    assign w_slot_free = !r_out_valid || !i_stall;

    assign w_cand    = r_pos + (AW + 1)'(r_step);
    assign w_take    = (w_cand <= MAX_POS) && (r_rd_a.pres == r_step);
    assign w_dpos_nx = w_take ? w_cand : r_pos;
    assign w_acc_nx  = r_acc + (w_take ? r_rd_b : '0);
    assign w_step_nx = r_step >> 1;
    assign w_cand_nx = w_dpos_nx + (AW + 1)'(w_step_nx);

    assign w_is_add     = (r_cmd == CMD_ADD);
    assign w_change     = w_is_add ? (r_rd_a.cnt != COUNT_MAX) : (r_rd_a.cnt != '0);
    assign w_lk_pchg    = w_is_add ? (r_rd_a.cnt == '0) : (r_rd_a.cnt == COUNT_W'(1));
    assign w_lk_cnt     = w_is_add ? r_rd_a.cnt + COUNT_W'(1) : r_rd_a.cnt - COUNT_W'(1);
    assign w_lk_delta_b = w_is_add ? RESULT_W'(1) : '1;
    assign w_lk_delta_p = !w_lk_pchg ? '0 : (w_is_add ? AW'(1) : '1);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_step      = r_step;
        n_up        = r_up;
        n_pchg      = r_pchg;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        rd_en       = 1'b0;
        rd_addr     = r_pos[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_pos[AW-1:0];
        wr_a        = r_rd_a;
        wr_b        = r_rd_b;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_a    = '0;
                wr_b    = '0;
                if (r_clr == MAX_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd = i_cmd;
                    n_pos = (AW + 1)'(i_value);
                    if (w_in_range) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(i_value);
                        n_state = S_LOOKUP;
                    end else begin
                        n_state = S_DSTART;
                    end
                end
            end
            S_LOOKUP: begin
                if (!w_change) begin
                    n_state = S_DSTART;
                end else begin
                    n_up      = w_is_add;
                    n_pchg    = w_lk_pchg;
                    wr_en     = 1'b1;
                    wr_a.cnt  = w_lk_cnt;
                    wr_a.pres = r_rd_a.pres + w_lk_delta_p;
                    wr_b      = r_rd_b + w_lk_delta_b;
                    n_pos     = w_next_pos;
                    if (w_next_pos <= MAX_POS) begin
                        rd_en   = 1'b1;
                        rd_addr = w_next_pos[AW-1:0];
                        n_state = S_WALK;
                    end else begin
                        n_state = S_DSTART;
                    end
                end
            end
            S_WALK: begin
                wr_en     = 1'b1;
                wr_a.pres = r_rd_a.pres + w_delta_p;
                wr_b      = r_rd_b + w_delta_b;
                n_pos     = w_next_pos;
                if (w_next_pos <= MAX_POS) begin
                    rd_en   = 1'b1;
                    rd_addr = w_next_pos[AW-1:0];
                end else begin
                    n_state = S_DSTART;
                end
            end
            S_DSTART: begin
                n_pos   = '0;
                n_step  = TOP_STEP;
                n_acc   = '0;
                rd_en   = 1'b1;
                rd_addr = TOP_STEP;
                n_state = S_DESC;
            end
            S_DESC: begin
                n_acc = w_acc_nx;
                if (r_step == AW'(1)) begin
                    if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = w_acc_nx;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_pos  = w_dpos_nx;
                    n_step = w_step_nx;
                    if (w_cand_nx <= MAX_POS) begin
                        rd_en   = 1'b1;
                        rd_addr = w_cand_nx[AW-1:0];
                    end
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pos      <= n_pos;
        r_step     <= n_step;
        r_up       <= n_up;
        r_pchg     <= n_pchg;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_a[wr_addr] <= wr_a;
            mem_b[wr_addr] <= wr_b;
        end
        if (rd_en) begin
            r_rd_a <= mem_a[rd_addr];
            r_rd_b <= mem_b[rd_addr];
        end
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_count_below_mex = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/mmpc_checker.sv =====
// port-level checks for the multiset mex prefix counter, bound to its top level
// depends on mmpc_pkg and multiset_mex_prefix_count
`default_nettype none

module mmpc_checker
    import mmpc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic [CMD_W-1:0]    i_cmd,
    input wire logic [VALUE_W-1:0]  i_value,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [RESULT_W-1:0] o_count_below_mex
);

    logic [1:0] r_pend;
    logic       w_in_beat;
    logic       w_out_beat;
    logic       w_in_known;

    assign w_in_beat  = i_valid && !o_stall;
    assign w_out_beat = o_valid && !i_stall;
    assign w_in_known = (i_cmd == CMD_ADD) || (i_cmd == CMD_REMOVE) || (i_value == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_beat && !w_out_beat && w_in_known) begin
            r_pend <= r_pend + 2'd1;
        end else if (w_out_beat && !w_in_beat && (r_pend != '0)) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_count_below_mex))
        else $error("output beat changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat && !w_in_beat |-> r_pend != 2'd0)
        else $error("output beat without an outstanding input beat");

    a_idle_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> r_pend <= 2'd1)
        else $error("input taken with an item still in work");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_stall && !o_valid)
        else $error("block ready or valid before clearing pass");

endmodule

bind multiset_mex_prefix_count mmpc_checker u_mmpc_checker (.*);

`default_nettype wire
